/* hdl/generic_data_asdu_parser_unit_assert.svh */
// Assertion macros used by the generic-data parser top level.
`ifndef GENERIC_DATA_ASDU_PARSER_UNIT_ASSERT_SVH
`define GENERIC_DATA_ASDU_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define GAPU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GAPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GAPU_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define GAPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/gapu_pkg.sv */
// Shared types and constants of the generic-data parser.
package gapu_pkg;

    // defaults for top-level parameters
    localparam int MAX_FRAME_BYTES_DEF = 255;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // configuration port
    localparam int         CFG_ADDR_W          = 3;
    localparam logic       CFG_IDX_EXPECTED    = 1'b0;
    localparam logic [7:0] EXPECTED_TYPE_RESET = 8'd10;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_ITEM    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // done status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_WRONG_TYPE = 2'd1;
    localparam logic [1:0] STATUS_SHORT      = 2'd2;

    // field masks
    localparam logic [7:0] ITEM_COUNT_MASK = 8'h3F;
    localparam logic [7:0] ELEM_COUNT_MASK = 8'h7F;
    localparam logic [7:0] CONT_BIT_MASK   = 8'h80;

    // smallest frame that holds a full header
    localparam logic [7:0] MIN_FRAME_BYTES = 8'd4;

    // classified input word, front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       last;
        logic [7:0] bytes_left;
        logic       bad_type;
        logic       short_frame;
    } gapu_word_t;

    // one result word
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  info_number;
        logic [7:0]  return_id;
        logic [7:0]  group_number;
        logic [7:0]  entry_number;
        logic [7:0]  description_kind;
        logic [7:0]  data_type;
        logic [7:0]  data_size;
        logic [6:0]  element_count;
        logic        cont_flag;
        logic [14:0] value;
        logic        last;
    } gapu_result_t;

    // queue status towards the top level
    typedef struct packed {
        logic full;
        logic empty;
    } gapu_queue_status_t;

endpackage

/* hdl/generic_data_asdu_parser_unit.sv */
// Generic-data information-object parser, top level.
// Takes one information-object byte per cycle while s_ready is high and emits header,
// item descriptor, payload byte and frame-done words. A byte that causes one result or
// none does not hold up the input; the last byte of a frame that also closes a header,
// descriptor or payload byte gives two words, and the back-end output register holds
// back the done word until the first is taken. A QUEUE_DEPTH-word queue (four by default)
// between the classifying front end and the parser absorbs that wait and output stalls.
// The expected type id register sits at byte address 0 of the APB port and resets to 10.
module generic_data_asdu_parser_unit #(
    parameter int MAX_FRAME_BYTES = gapu_pkg::MAX_FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH     = gapu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gapu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_frame_start,
    input  logic [7:0]                    s_bytes_left,
    input  logic [7:0]                    s_type_id,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_result_kind,
    output logic [7:0]                    m_info_number,
    output logic [7:0]                    m_return_id,
    output logic [7:0]                    m_group_number,
    output logic [7:0]                    m_entry_number,
    output logic [7:0]                    m_description_kind,
    output logic [7:0]                    m_data_type,
    output logic [7:0]                    m_data_size,
    output logic [6:0]                    m_element_count,
    output logic                          m_cont_flag,
    output logic [14:0]                   m_value,
    output logic                          m_last
);

`include "generic_data_asdu_parser_unit_assert.svh"

    logic [7:0]                   exp_type_reg;
    logic                         cfg_write;
    gapu_pkg::gapu_word_t         front_word;
    gapu_pkg::gapu_word_t         back_word;
    gapu_pkg::gapu_queue_status_t q_status;
    gapu_pkg::gapu_result_t       result;
    logic                         q_pop_valid, q_pop_ready;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == gapu_pkg::CFG_IDX_EXPECTED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_type_reg <= gapu_pkg::EXPECTED_TYPE_RESET;
        end else if (cfg_write) begin
            exp_type_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        if (paddr[2] == gapu_pkg::CFG_IDX_EXPECTED) begin
            prdata = {24'b0, exp_type_reg};
        end else begin
            prdata = '0;
        end
    end

    gapu_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .data_byte       (s_data_byte),
        .frame_start     (s_frame_start),
        .bytes_left      (s_bytes_left),
        .type_id         (s_type_id),
        .expected_type_id(exp_type_reg),
        .word            (front_word)
    );

    gapu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(s_valid),
        .push_ready(s_ready),
        .push_word (front_word),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_word  (back_word),
        .status    (q_status)
    );

    gapu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_word  (back_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_result(result)
    );

    // result fields
    assign m_result_kind      = result.result_kind;
    assign m_info_number      = result.info_number;
    assign m_return_id        = result.return_id;
    assign m_group_number     = result.group_number;
    assign m_entry_number     = result.entry_number;
    assign m_description_kind = result.description_kind;
    assign m_data_type        = result.data_type;
    assign m_data_size        = result.data_size;
    assign m_element_count    = result.element_count;
    assign m_cont_flag        = result.cont_flag;
    assign m_value            = result.value;
    assign m_last             = result.last;

    // a done word always closes its byte and carries a known status
    `GAPU_ASSERT_IMPL(a_done_is_last, aclk, aresetn, m_valid && m_result_kind == gapu_pkg::KIND_DONE, m_last && m_value < 15'd3, "done word not last or bad status")
    // the word after a non-last word is the done word, issued at once
    `GAPU_ASSERT_NEXT(a_done_follows, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_result_kind == gapu_pkg::KIND_DONE, "done word missing after first word")
    // the queue cannot be full and empty at once
    `GAPU_ASSERT_IMPL(a_queue_state, aclk, aresetn, q_status.full, !q_status.empty && q_pop_valid, "queue full but empty")

endmodule

/* hdl/gapu_front.sv */
// Front end: clamps the byte count and classifies each incoming byte.
module gapu_front #(
    parameter int MAX_FRAME_BYTES = gapu_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic [7:0]        data_byte,
    input  logic              frame_start,
    input  logic [7:0]        bytes_left,
    input  logic [7:0]        type_id,
    input  logic [7:0]        expected_type_id,
    output gapu_pkg::gapu_word_t word
);

    logic [7:0] blen_clamped;

    // counts above the frame limit are taken as the limit
    always_comb begin
        if (32'(bytes_left) > MAX_FRAME_BYTES) begin
            blen_clamped = 8'(MAX_FRAME_BYTES);
        end else begin
            blen_clamped = bytes_left;
        end
    end

    // classification used by the back end
    always_comb begin
        word.data_byte   = data_byte;
        word.frame_start = frame_start;
        word.bytes_left  = blen_clamped;
        word.last        = (blen_clamped <= 8'd1);
        word.bad_type    = (type_id != expected_type_id);
        word.short_frame = (blen_clamped < gapu_pkg::MIN_FRAME_BYTES);
    end

endmodule

/* hdl/gapu_queue.sv */
// Short word queue between the front and back ends.
module gapu_queue #(
    parameter int DEPTH = gapu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push_valid,
    output logic                         push_ready,
    input  gapu_pkg::gapu_word_t         push_word,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output gapu_pkg::gapu_word_t         pop_word,
    output gapu_pkg::gapu_queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gapu_pkg::gapu_word_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready   = (count_reg != CNT_W'(DEPTH));
    assign pop_valid    = (count_reg != '0);
    assign pop_word     = store_reg[rd_ptr_reg];
    assign status.full  = !push_ready;
    assign status.empty = !pop_valid;
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* hdl/gapu_back.sv */
// Back end: frame parser state machine and result output register.
module gapu_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  gapu_pkg::gapu_word_t   pop_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gapu_pkg::gapu_result_t out_result
);

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEAD    = 5'b00010,
        PH_ITEM    = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_SKIP    = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [2:0]  fld_idx_reg, fld_idx_next;
    logic [5:0]  items_exp_reg, items_exp_next;
    logic [5:0]  items_done_reg, items_done_next;
    logic [14:0] pay_rem_reg, pay_rem_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  info_reg, info_next;
    logic [7:0]  ret_id_reg, ret_id_next;
    logic [7:0]  held_reg [5];
    logic [7:0]  held_next [5];

    logic                   out_valid_reg, out_valid_next;
    gapu_pkg::gapu_result_t out_reg, out_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             pend_status_reg, pend_status_next;

    logic                   slot_free, consume;
    logic                   r0_valid, done_valid;
    gapu_pkg::gapu_result_t r0;
    logic [7:0]             b;
    logic [6:0]             count;
    logic [14:0]            plen;
    logic                   fits;

    assign slot_free  = !out_valid_reg || out_ready;
    assign pop_ready  = slot_free && !pend_reg;
    assign consume    = pop_valid && pop_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign b     = pop_word.data_byte;
    assign count = 7'(b & gapu_pkg::ELEM_COUNT_MASK);
    assign plen  = 15'(held_reg[4]) * 15'(count);
    assign fits  = ({1'b0, plen} + 16'd1) <= {8'b0, pop_word.bytes_left};

    // parser step for one consumed word
    always_comb begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        fld_idx_next    = fld_idx_reg;
        items_exp_next  = items_exp_reg;
        items_done_next = items_done_reg;
        pay_rem_next    = pay_rem_reg;
        status_next     = status_reg;
        info_next       = info_reg;
        ret_id_next     = ret_id_reg;
        held_next       = held_reg;
        r0_valid        = 1'b0;
        r0              = '0;
        done_valid      = 1'b0;
        if (consume && (pop_word.frame_start || phase_reg != PH_IDLE)) begin
            // new frame: clear counters and check type and length
            if (pop_word.frame_start) begin
                hdr_idx_next    = '0;
                fld_idx_next    = '0;
                items_exp_next  = '0;
                items_done_next = '0;
                pay_rem_next    = '0;
                if (pop_word.bad_type) begin
                    status_next = gapu_pkg::STATUS_WRONG_TYPE;
                end else if (pop_word.short_frame) begin
                    status_next = gapu_pkg::STATUS_SHORT;
                end else begin
                    status_next = gapu_pkg::STATUS_OK;
                end
                phase_next = (status_next != gapu_pkg::STATUS_OK) ? PH_SKIP : PH_HEAD;
            end
            case (phase_next)
                PH_HEAD: begin
                    // function byte, info number, return id, item count
                    if (hdr_idx_next == 2'd3) begin
                        items_exp_next  = 6'(b & gapu_pkg::ITEM_COUNT_MASK);
                        items_done_next = '0;
                        fld_idx_next    = '0;
                        r0_valid        = 1'b1;
                        r0.result_kind  = gapu_pkg::KIND_HEADER;
                        r0.info_number  = info_next;
                        r0.return_id    = ret_id_next;
                        r0.cont_flag    = |(b & gapu_pkg::CONT_BIT_MASK);
                        r0.value        = 15'(items_exp_next);
                        phase_next      = (items_exp_next != '0) ? PH_ITEM : PH_SKIP;
                    end else begin
                        if (hdr_idx_next == 2'd1) begin
                            info_next = b;
                        end else if (hdr_idx_next == 2'd2) begin
                            ret_id_next = b;
                        end
                        hdr_idx_next = hdr_idx_next + 2'd1;
                    end
                end
                PH_ITEM: begin
                    if (fld_idx_next < 3'd5) begin
                        held_next[fld_idx_next] = b;
                        fld_idx_next = fld_idx_next + 3'd1;
                    end else begin
                        // count byte closes the descriptor
                        r0_valid            = 1'b1;
                        r0.result_kind      = gapu_pkg::KIND_ITEM;
                        r0.group_number     = held_reg[0];
                        r0.entry_number     = held_reg[1];
                        r0.description_kind = held_reg[2];
                        r0.data_type        = held_reg[3];
                        r0.data_size        = held_reg[4];
                        r0.element_count    = count;
                        r0.cont_flag        = |(b & gapu_pkg::CONT_BIT_MASK);
                        r0.value            = fits ? plen : '0;
                        fld_idx_next        = '0;
                        if (fits && plen != '0) begin
                            pay_rem_next = plen;
                            phase_next   = PH_PAYLOAD;
                        end else begin
                            items_done_next = items_done_next + 6'd1;
                            phase_next = (items_done_next == items_exp_next) ? PH_SKIP : PH_ITEM;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r0_valid       = 1'b1;
                    r0.result_kind = gapu_pkg::KIND_PAYLOAD;
                    r0.value       = 15'(b);
                    if (pay_rem_next != '0) begin
                        pay_rem_next = pay_rem_next - 15'd1;
                    end
                    if (pay_rem_next == '0) begin
                        items_done_next = items_done_next + 6'd1;
                        phase_next = (items_done_next == items_exp_next) ? PH_SKIP : PH_ITEM;
                    end
                end
                default: begin
                end
            endcase
            // last byte of the frame closes it
            if (pop_word.last) begin
                if (status_next == gapu_pkg::STATUS_OK && phase_next == PH_HEAD) begin
                    status_next = gapu_pkg::STATUS_SHORT;
                end
                done_valid = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    // output register with a held-back done word
    always_comb begin
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        if (consume) begin
            if (r0_valid) begin
                out_valid_next = 1'b1;
                out_next       = r0;
                out_next.last  = !done_valid;
                if (done_valid) begin
                    pend_next        = 1'b1;
                    pend_status_next = status_next;
                end
            end else if (done_valid) begin
                out_valid_next    = 1'b1;
                out_next          = '0;
                out_next.result_kind = gapu_pkg::KIND_DONE;
                out_next.value    = 15'(status_next);
                out_next.last     = 1'b1;
            end
        end else if (pend_reg && slot_free) begin
            out_valid_next       = 1'b1;
            out_next             = '0;
            out_next.result_kind = gapu_pkg::KIND_DONE;
            out_next.value       = 15'(pend_status_reg);
            out_next.last        = 1'b1;
            pend_next            = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hdr_idx_reg    <= '0;
            fld_idx_reg    <= '0;
            items_exp_reg  <= '0;
            items_done_reg <= '0;
            pay_rem_reg    <= '0;
            status_reg     <= gapu_pkg::STATUS_OK;
            info_reg       <= '0;
            ret_id_reg     <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            fld_idx_reg    <= fld_idx_next;
            items_exp_reg  <= items_exp_next;
            items_done_reg <= items_done_next;
            pay_rem_reg    <= pay_rem_next;
            status_reg     <= status_next;
            info_reg       <= info_next;
            ret_id_reg     <= ret_id_next;
            out_valid_reg  <= out_valid_next;
            pend_reg       <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        held_reg        <= held_next;
        out_reg         <= out_next;
        pend_status_reg <= pend_status_next;
    end

endmodule
